// ----- rtl/ksc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ksc_pkg;

  localparam int NumSlotsDef   = 64;
  localparam int IdxW          = 16;
  localparam int NameW         = 32;
  localparam int DimW          = 15;
  localparam int BytesW        = 31;
  localparam int HashW         = 64;
  localparam int SlotOutW      = 6;
  localparam int StatusW       = 3;
  localparam int BytesPerPixel = 4;

  typedef enum logic [1:0] {
    MODE_AUTO    = 2'd0,
    MODE_SLOT    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_ZERO_DIM = 3'd1,
    STATUS_BYTES    = 3'd2,
    STATUS_RANGE    = 3'd3,
    STATUS_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FIN,
    ST_OUT
  } state_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic             reserved;
    logic             mapped;
    logic [NameW-1:0] name;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [HashW-1:0] hash;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/ksc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/ksc_key_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ksc_key_check (
  input  wire logic [ksc_pkg::DimW-1:0]   tex_width,
  input  wire logic [ksc_pkg::DimW-1:0]   tex_height,
  input  wire logic [ksc_pkg::BytesW-1:0] byte_count,
  output ksc_pkg::status_t                chk_status
);
  import ksc_pkg::*;

  localparam int BppShift = $clog2(BytesPerPixel);
  localparam int AreaW    = 2 * DimW;
  localparam int ProdW    = AreaW + BppShift;

  logic [AreaW-1:0] area;
  logic [ProdW-1:0] need;

  assign area = AreaW'(tex_width) * AreaW'(tex_height);
  assign need = ProdW'(area) << BppShift;

  always_comb begin
    if (tex_width == '0 || tex_height == '0) begin
      chk_status = STATUS_ZERO_DIM;
    end else if (need != ProdW'(byte_count)) begin
      chk_status = STATUS_BYTES;
    end else begin
      chk_status = STATUS_OK;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ksc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ksc_seq #(
  parameter int NUM_SLOTS = ksc_pkg::NumSlotsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [ksc_pkg::IdxW-1:0]      in_slot_index,
  input  wire logic [ksc_pkg::NameW-1:0]     in_name_tag,
  input  wire logic [ksc_pkg::DimW-1:0]      in_tex_width,
  input  wire logic [ksc_pkg::DimW-1:0]      in_tex_height,
  input  wire logic [ksc_pkg::BytesW-1:0]    in_byte_count,
  input  wire logic [ksc_pkg::HashW-1:0]     in_content_hash,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ksc_pkg::SlotOutW-1:0]       out_assigned_slot,
  output logic                               out_cache_hit,
  output logic                               out_queued,
  output logic [ksc_pkg::StatusW-1:0]        out_status,
  output logic                               ram_we,
  output logic [$clog2(NUM_SLOTS)-1:0]       ram_waddr,
  output ksc_pkg::entry_t                    ram_wdata,
  output logic [$clog2(NUM_SLOTS)-1:0]       ram_raddr,
  input  wire ksc_pkg::entry_t               ram_rdata
);
  import ksc_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = AW + 1;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pipe_v_r, pipe_v_nxt;
  logic          pipe_last_r, pipe_last_nxt;
  logic [AW-1:0] pipe_addr_r, pipe_addr_nxt;
  logic          clr_req_r, clr_req_nxt;

  mode_t              mode_r, mode_nxt;
  logic [IdxW-1:0]    idx_r, idx_nxt;
  logic [NameW-1:0]   name_r, name_nxt;
  logic [DimW-1:0]    w_r, w_nxt;
  logic [DimW-1:0]    h_r, h_nxt;
  logic [BytesW-1:0]  bytes_r, bytes_nxt;
  logic [HashW-1:0]   hash_r, hash_nxt;

  logic          hit_found_r, hit_found_nxt;
  logic [AW-1:0] hit_slot_r, hit_slot_nxt;
  logic          free_found_r, free_found_nxt;
  logic [AW-1:0] free_slot_r, free_slot_nxt;

  logic [AW-1:0] res_slot_r, res_slot_nxt;
  logic          res_hit_r, res_hit_nxt;
  logic          res_queued_r, res_queued_nxt;
  status_t       res_status_r, res_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SlotOutW-1:0] out_slot_r, out_slot_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_queued_r, out_queued_nxt;
  status_t             out_status_r, out_status_nxt;

  status_t                chk_status;
  logic                   idx_ok;
  logic [AW-1:0]          idx_slot;
  logic                   key_eq;
  entry_t                 new_entry;
  entry_t                 clear_entry;
  entry_t                 unmap_entry;
  logic [AW+SlotOutW-1:0] slot_ext;

  ksc_key_check u_key_check (
    .tex_width  (w_r),
    .tex_height (h_r),
    .byte_count (bytes_r),
    .chk_status (chk_status)
  );

  assign idx_ok   = {1'b0, idx_r} < (IdxW + 1)'(NUM_SLOTS);
  assign idx_slot = idx_r[AW-1:0];
  assign key_eq   = ram_rdata.name == name_r && ram_rdata.width == w_r &&
                    ram_rdata.height == h_r && ram_rdata.hash == hash_r;
  assign slot_ext = {{SlotOutW{1'b0}}, res_slot_r};

  always_comb begin
    new_entry          = '0;
    new_entry.reserved = 1'b1;
    new_entry.mapped   = 1'b1;
    new_entry.name     = name_r;
    new_entry.width    = w_r;
    new_entry.height   = h_r;
    new_entry.hash     = hash_r;
    // key bits of a free entry are never looked at
    clear_entry          = new_entry;
    clear_entry.reserved = 1'b0;
    clear_entry.mapped   = 1'b0;
    unmap_entry          = ram_rdata;
    unmap_entry.mapped   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      pipe_v_r    <= 1'b0;
      pipe_last_r <= 1'b0;
      clr_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pipe_v_r    <= pipe_v_nxt;
      pipe_last_r <= pipe_last_nxt;
      clr_req_r   <= clr_req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr_r  <= pipe_addr_nxt;
    mode_r       <= mode_nxt;
    idx_r        <= idx_nxt;
    name_r       <= name_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    bytes_r      <= bytes_nxt;
    hash_r       <= hash_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_slot_r   <= hit_slot_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    res_slot_r   <= res_slot_nxt;
    res_hit_r    <= res_hit_nxt;
    res_queued_r <= res_queued_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_queued_r <= out_queued_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pipe_v_nxt     = 1'b0;
    pipe_last_nxt  = 1'b0;
    pipe_addr_nxt  = cnt_r[AW-1:0];
    clr_req_nxt    = clr_req_r;
    mode_nxt       = mode_r;
    idx_nxt        = idx_r;
    name_nxt       = name_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    bytes_nxt      = bytes_r;
    hash_nxt       = hash_r;
    hit_found_nxt  = hit_found_r;
    hit_slot_nxt   = hit_slot_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    res_slot_nxt   = res_slot_r;
    res_hit_nxt    = res_hit_r;
    res_queued_nxt = res_queued_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_hit_nxt    = out_hit_r;
    out_queued_nxt = out_queued_r;
    out_status_nxt = out_status_r;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_wdata      = clear_entry;
    ram_raddr      = cnt_r[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        // one entry a cycle, after reset and for a clear-all beat
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_SLOTS - 1)) begin
          cnt_nxt     = '0;
          clr_req_nxt = 1'b0;
          state_nxt   = clr_req_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt       = mode_t'(in_mode);
          idx_nxt        = in_slot_index;
          name_nxt       = in_name_tag;
          w_nxt          = in_tex_width;
          h_nxt          = in_tex_height;
          bytes_nxt      = in_byte_count;
          hash_nxt       = in_content_hash;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          res_slot_nxt   = '0;
          res_hit_nxt    = 1'b0;
          res_queued_nxt = 1'b0;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        case (mode_r)
          MODE_CLEAR: begin
            clr_req_nxt = 1'b1;
            state_nxt   = ST_CLR;
          end
          MODE_RELEASE: begin
            if (!idx_ok) begin
              res_status_nxt = STATUS_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = idx_slot;
            end
            state_nxt = ST_OUT;
          end
          default: begin
            if (chk_status != STATUS_OK) begin
              res_status_nxt = chk_status;
              state_nxt      = ST_OUT;
            end else if (mode_r == MODE_SLOT && !idx_ok) begin
              res_status_nxt = STATUS_RANGE;
              state_nxt      = ST_OUT;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (cnt_r < CW'(NUM_SLOTS)) begin
          pipe_v_nxt    = 1'b1;
          pipe_last_nxt = cnt_r == CW'(NUM_SLOTS - 1);
          cnt_nxt       = cnt_r + 1'b1;
        end
        // read data for pipe_addr_r; each entry is touched once, no hazard
        if (pipe_v_r) begin
          if (mode_r == MODE_AUTO) begin
            if (!hit_found_r && ram_rdata.mapped && key_eq) begin
              hit_found_nxt = 1'b1;
              hit_slot_nxt  = pipe_addr_r;
            end
            if (!free_found_r && !ram_rdata.reserved) begin
              free_found_nxt = 1'b1;
              free_slot_nxt  = pipe_addr_r;
            end
          end else begin
            ram_waddr = pipe_addr_r;
            if (pipe_addr_r == idx_slot) begin
              ram_we        = 1'b1;
              ram_wdata     = new_entry;
              hit_found_nxt = ram_rdata.reserved && key_eq;
            end else if (ram_rdata.mapped && key_eq) begin
              // key moves to the requested slot
              ram_we    = 1'b1;
              ram_wdata = unmap_entry;
            end
          end
          if (pipe_last_r) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (mode_r == MODE_SLOT) begin
          res_slot_nxt   = idx_slot;
          res_hit_nxt    = hit_found_r;
          res_queued_nxt = !hit_found_r;
        end else if (hit_found_r) begin
          res_slot_nxt = hit_slot_r;
          res_hit_nxt  = 1'b1;
        end else if (free_found_r) begin
          ram_we         = 1'b1;
          ram_waddr      = free_slot_r;
          ram_wdata      = new_entry;
          res_slot_nxt   = free_slot_r;
          res_queued_nxt = 1'b1;
        end else begin
          res_status_nxt = STATUS_FULL;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slot_ext[SlotOutW-1:0];
          out_hit_nxt    = res_hit_r;
          out_queued_nxt = res_queued_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_assigned_slot = out_slot_r;
  assign out_cache_hit     = out_hit_r;
  assign out_queued        = out_queued_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

// ----- rtl/keyed_slot_cache_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Texture slot table keyed by name tag, width, height and content hash, held in
// one single-port-write, registered-read memory of NUM_SLOTS entries. One
// request is in flight at a time. Auto and slot requests that pass the checks
// walk the whole table once through the memory read port (compare keys; auto
// requests also find the first free slot, slot requests drop duplicate mappings
// on the fly), then pass the finish and output states before the result is
// registered on the output. Release, range and key errors go from the check
// state straight to the output state. Clear all and the pass that follows reset
// write every entry, one per cycle; a clear-all result follows its pass, and no
// request is accepted during the pass after reset. A new request is accepted
// while the previous result still waits on the output.
module keyed_slot_cache_allocator #(
  parameter int NUM_SLOTS = ksc_pkg::NumSlotsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [ksc_pkg::IdxW-1:0]      in_slot_index,
  input  wire logic [ksc_pkg::NameW-1:0]     in_name_tag,
  input  wire logic [ksc_pkg::DimW-1:0]      in_tex_width,
  input  wire logic [ksc_pkg::DimW-1:0]      in_tex_height,
  input  wire logic [ksc_pkg::BytesW-1:0]    in_byte_count,
  input  wire logic [ksc_pkg::HashW-1:0]     in_content_hash,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ksc_pkg::SlotOutW-1:0]       out_assigned_slot,
  output logic                               out_cache_hit,
  output logic                               out_queued,
  output logic [ksc_pkg::StatusW-1:0]        out_status
);
  import ksc_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  ksc_seq #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_slot_index     (in_slot_index),
    .in_name_tag       (in_name_tag),
    .in_tex_width      (in_tex_width),
    .in_tex_height     (in_tex_height),
    .in_byte_count     (in_byte_count),
    .in_content_hash   (in_content_hash),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_assigned_slot (out_assigned_slot),
    .out_cache_hit     (out_cache_hit),
    .out_queued        (out_queued),
    .out_status        (out_status),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata)
  );

  ksc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
